FILE: design/lkv_pkg.sv
// lkv_pkg: shared types and constants for the LRU key/value cache core.
// Used by lkv_cell and lru_key_value_cache_core. No dependencies.

package lkv_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
   localparam logic signed [DATA_W-1:0]  MISS_VALUE = 32'hFFFF_FFFF;
   localparam logic signed [DATA_W-1:0]  PUT_VALUE  = 32'h0000_0000;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // one stored entry, also what a cell hands to its neighbor on a shift
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   // search token travelling down the chain
   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] value;
   } tok_type;

endpackage

FILE: design/lru_key_value_cache_core.sv
// lru_key_value_cache_core: top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg and lkv_cell.
//
// Usage:
//   Request channel: drive req_op/req_key/req_value and raise start; the
//   transaction is taken at a clock edge with start high and busy low.
//   req_op 0 is a get, 1 is a put.
//   Response channel: one transaction per request, shown on rsp_hit,
//   rsp_read_value and rsp_evicted for exactly one cycle with rsp_valid high.
//   The receiver cannot stall; it must capture the response in that cycle.
//   busy stays high until the response is registered, so a new request is
//   taken no earlier than the cycle that shows it. The key is searched by a
//   token that walks the chain of ENTRIES cells one cell per clock; the
//   move-to-front shift of the chain is registered with the response.
//   Entries are kept in recency order, cell 0 most recent.
//   Capacity: csr_wr_en/csr_wr_data writes capacity_in_use (0 acts as 1,
//   values above ENTRIES act as ENTRIES); write only while idle.
//   Reset: synchronous, clears all valid bits and the occupancy, capacity
//   returns to 16; the core is ready the cycle after reset drops.

module lru_key_value_cache_core #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic signed [lkv_pkg::DATA_W-1:0] req_key,
   input  logic signed [lkv_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic signed [lkv_pkg::DATA_W-1:0] rsp_read_value,
   output logic                             rsp_evicted,
   input  logic                             csr_wr_en,
   input  logic [lkv_pkg::CAP_W-1:0]        csr_wr_data
);
   import lkv_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic                     busy_ff, busy_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   logic                     op_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CAP_W-1:0]         cap_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic signed [DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic                     rsp_evicted_ff, rsp_evicted_in;

   tok_type          tok_chain [0:ENTRIES];
   logic [IDX_W-1:0] pos_chain [0:ENTRIES];
   entry_type        ent_chain [0:ENTRIES];

   logic             accept;
   logic             last;
   logic             upd_en;
   logic [IDX_W-1:0] shift_lim;
   logic [CMP_W-1:0] eff_cap;
   logic             full;
   logic [CNT_W-1:0] cnt_m1;
   tok_type          fin_tok;

   assign tok_chain[0] = '{found: 1'b0, value: '0};
   assign pos_chain[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         lkv_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .srch_key  (key_ff),
            .up_tok    (tok_chain[gi]),
            .up_pos    (pos_chain[gi]),
            .dn_tok    (tok_chain[gi+1]),
            .dn_pos    (pos_chain[gi+1]),
            .upd_en    (upd_en),
            .shift_lim (shift_lim),
            .nbr_ent   (ent_chain[gi]),
            .ent       (ent_chain[gi+1])
         );
      end
   endgenerate

   always_comb begin
      accept  = start && !busy_ff;
      last    = busy_ff && (step_ff == CNT_W'(ENTRIES));
      fin_tok = tok_chain[ENTRIES];

      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
      full   = CMP_W'(count_ff) >= eff_cap;
      cnt_m1 = count_ff - CNT_W'(1);

      upd_en = last && (fin_tok.found || (op_ff == OP_PUT));
      priority if (fin_tok.found) begin
         shift_lim = pos_chain[ENTRIES];
      end else if (full) begin
         shift_lim = cnt_m1[IDX_W-1:0];
      end else begin
         shift_lim = count_ff[IDX_W-1:0];
      end

      ent_chain[0].valid = 1'b1;
      ent_chain[0].key   = key_ff;
      ent_chain[0].value = (op_ff == OP_PUT) ? value_ff : fin_tok.value;

      busy_in  = busy_ff;
      step_in  = step_ff;
      count_in = count_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (last) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         step_in = step_ff + CNT_W'(1);
      end
      if (last && (op_ff == OP_PUT) && !fin_tok.found && !full) begin
         count_in = count_ff + CNT_W'(1);
      end

      rsp_valid_in      = last;
      rsp_hit_in        = fin_tok.found;
      rsp_evicted_in    = (op_ff == OP_PUT) && !fin_tok.found && full;
      if (op_ff == OP_PUT) begin
         rsp_read_value_in = PUT_VALUE;
      end else if (fin_tok.found) begin
         rsp_read_value_in = fin_tok.value;
      end else begin
         rsp_read_value_in = MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (last) begin
         rsp_hit_ff        <= rsp_hit_in;
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_evicted_ff    <= rsp_evicted_in;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

`ifndef ASSERT_OFF
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("response while a transaction is still in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted transaction did not raise busy");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ENTRIES) >= count_ff)
      else $error("occupancy above entry count");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");
`endif

endmodule

FILE: design/lkv_cell.sv
// lkv_cell: one entry of the recency-ordered chain plus one stage of the search wave.
// Depends on lkv_pkg (entry_type, tok_type).

module lkv_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [lkv_pkg::DATA_W-1:0] srch_key,
   input  lkv_pkg::tok_type                 up_tok,
   input  logic [IDX_W-1:0]                 up_pos,
   output lkv_pkg::tok_type                 dn_tok,
   output logic [IDX_W-1:0]                 dn_pos,
   input  logic                             upd_en,
   input  logic [IDX_W-1:0]                 shift_lim,
   input  lkv_pkg::entry_type               nbr_ent,
   output lkv_pkg::entry_type               ent
);
   import lkv_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                     valid_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [DATA_W-1:0] value_ff;
   tok_type                  tok_ff, tok_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic                     match;
   logic                     shift_en;

   always_comb begin
      match    = valid_ff && (key_ff == srch_key);
      shift_en = upd_en && (MY_IDX <= shift_lim);
      tok_in   = up_tok;
      pos_in   = up_pos;
      if (!up_tok.found && match) begin
         tok_in.found = 1'b1;
         tok_in.value = value_ff;
         pos_in       = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= nbr_ent.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         key_ff   <= nbr_ent.key;
         value_ff <= nbr_ent.value;
      end
      tok_ff <= tok_in;
      pos_ff <= pos_in;
   end

   assign dn_tok = tok_ff;
   assign dn_pos = pos_ff;
   assign ent    = '{valid: valid_ff, key: key_ff, value: value_ff};

endmodule
